// ----- src/montgomery_modular_exponentiation_unit_macros.svh -----
// Assertion helpers for the RTL, included by mmeu_ctrl.sv.
`ifndef MONTGOMERY_MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MONTGOMERY_MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising clock edge while reset is released.
`define MMEU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define MMEU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MMEU_ASSERT(lbl, prop, msg)
`define MMEU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- src/mmeu_pkg.sv -----
package mmeu_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [2*WORD_W-1:0] t_dword;

    // Configuration register indexes.
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MODULUS  = 1'b0;
    localparam t_cfg_idx CFG_EXPONENT = 1'b1;

    // Shared step counter: covers the 64 doubling steps.
    typedef logic [5:0] t_cnt;
    localparam t_cnt INV_LAST = 6'd4;
    localparam t_cnt DBL_LAST = 6'd63;
    localparam logic [4:0] BIT_LAST = 5'd31;

    // Montgomery reductions issued by the sequencer.
    typedef enum logic [2:0] {
        OP_X0    = 3'd0,
        OP_ACC0  = 3'd1,
        OP_MULT  = 3'd2,
        OP_SQR   = 3'd3,
        OP_FINAL = 3'd4
    } t_op;

    // Completion handed from the sequencer to the output stage.
    typedef struct packed {
        logic  done;
        logic  err;
        t_word result;
    } t_res;

endpackage

// ----- src/mmeu_in_if.sv -----
interface mmeu_in_if import mmeu_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word base;

    modport source (output valid, output base, input ready);
    modport sink   (input valid, input base, output ready);
endinterface

// ----- src/mmeu_out_if.sv -----
interface mmeu_out_if import mmeu_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word result;
    logic  modulus_error;

    modport source (output valid, output result, output modulus_error, input ready);
    modport sink   (input valid, input result, input modulus_error, output ready);
endinterface

// ----- src/montgomery_modular_exponentiation_unit.sv -----
// Montgomery modular exponentiation, 32-bit: result = base^exponent mod modulus.
// Configure modulus (index 0, reset 1) and exponent (index 1, reset 0) through
// the write port while the unit is idle; each write lands on the clock edge at
// which i_cfg_we is high. Each base item on i_in produces exactly one item on
// o_out carrying the result and a modulus_error flag. A zero or even modulus
// yields result 0 with modulus_error set; the sequencer goes straight to done.
// For a valid modulus one 32x32 multiplier, shared under a small sequencer,
// forms every product. The sequencer derives n^-1 mod 2^32, runs modular
// doubling to derive R^2 mod n, brings base and one into Montgomery form,
// does a square per exponent bit plus a multiply per set bit, and ends with
// the final conversion.
// The unit takes one item at a time, since i_in.ready is high only when the
// sequencer is idle.
// Results sit in an output register, so a new item is accepted while an earlier
// result still waits for the receiver. If the receiver stalls and a second
// result is ready, the sequencer holds it until the output register frees up.
// Synchronous active-low reset returns the sequencer to idle, empties the
// output register and restores the configuration registers.
module montgomery_modular_exponentiation_unit import mmeu_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mmeu_in_if.sink         i_in,
    mmeu_out_if.source      o_out,
    input  logic            i_cfg_we,
    input  t_cfg_idx        i_cfg_idx,
    input  t_word           i_cfg_data
);

    t_word r_modulus;
    t_word r_exponent;
    logic  r_ovalid;
    t_word r_result;
    logic  r_err;

    logic  seq_ready;
    logic  slot_free;
    t_res  seq_res;

    // The output register can take a result when empty or being drained.
    assign slot_free = !r_ovalid || o_out.ready;

    mmeu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in.valid && seq_ready),
        .i_base      (i_in.base),
        .i_modulus   (r_modulus),
        .i_exponent  (r_exponent),
        .i_slot_free (slot_free),
        .o_ready     (seq_ready),
        .o_res       (seq_res)
    );

    assign i_in.ready = seq_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= 32'd1;
            r_exponent <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                default:      r_modulus  <= r_modulus;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (seq_res.done) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res.done) begin
            r_result <= seq_res.result;
            r_err    <= seq_res.err;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.result        = r_result;
    assign o_out.modulus_error = r_err;

endmodule

// ----- src/mmeu_mul.sv -----
module mmeu_mul import mmeu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_word  i_a,
    input  t_word  i_b,
    output t_dword o_p
);

    t_dword r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= t_dword'(i_a) * t_dword'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

// ----- src/mmeu_ctrl.sv -----
`include "montgomery_modular_exponentiation_unit_macros.svh"

module mmeu_ctrl import mmeu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_base,
    input  t_word i_modulus,
    input  t_word i_exponent,
    input  logic  i_slot_free,
    output logic  o_ready,
    output t_res  o_res
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_NA   = 10'b0000000010,
        S_NB   = 10'b0000000100,
        S_NC   = 10'b0000001000,
        S_DBL  = 10'b0000010000,
        S_PROD = 10'b0000100000,
        S_RA   = 10'b0001000000,
        S_RB   = 10'b0010000000,
        S_RC   = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_cnt   r_cnt, n_cnt;
    t_word  r_n, n_n;
    t_word  r_e, n_e;
    t_word  r_base, n_base;
    t_word  r_ninv, n_ninv;
    t_word  r_rem, n_rem;
    t_word  r_x, n_x;
    t_word  r_acc, n_acc;
    t_dword r_t, n_t;
    t_word  r_res, n_res;
    logic   r_err, n_err;

    logic   mul_en;
    t_word  mul_a, mul_b;
    t_dword mul_p;

    t_dword     t_src;
    t_dword     diff;
    t_word      red;
    logic [WORD_W:0] rem2;
    logic [4:0] nxt_bit;

    mmeu_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_e     = r_e;
        n_base  = r_base;
        n_ninv  = r_ninv;
        n_rem   = r_rem;
        n_x     = r_x;
        n_acc   = r_acc;
        n_t     = r_t;
        n_res   = r_res;
        n_err   = r_err;
        mul_en  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        o_res   = '{done: 1'b0, err: r_err, result: r_res};

        // Operand of a reduction: a fresh product or a single word.
        if (r_op == OP_X0 || r_op == OP_MULT || r_op == OP_SQR) begin
            t_src = mul_p;
        end else if (r_op == OP_ACC0) begin
            t_src = {{WORD_W{1'b0}}, r_rem};
        end else begin
            t_src = {{WORD_W{1'b0}}, r_acc};
        end

        // (t - m*n) / R, adding n back when the difference went negative.
        diff    = r_t - mul_p;
        red     = diff[2*WORD_W-1:WORD_W] + ((r_t < mul_p) ? r_n : '0);
        rem2    = {r_rem, 1'b0};
        nxt_bit = r_cnt[4:0] + 5'd1;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_base = i_base;
                    n_n    = i_modulus;
                    n_e    = i_exponent;
                    n_ninv = i_modulus;
                    n_cnt  = '0;
                    if (i_modulus == '0 || !i_modulus[0]) begin
                        n_res   = '0;
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_NA;
                    end
                end
            end
            S_NA: begin
                mul_en  = 1'b1;
                mul_a   = r_n;
                mul_b   = r_ninv;
                n_state = S_NB;
            end
            S_NB: begin
                mul_en  = 1'b1;
                mul_a   = r_ninv;
                mul_b   = 32'd2 - mul_p[WORD_W-1:0];
                n_state = S_NC;
            end
            S_NC: begin
                n_ninv = mul_p[WORD_W-1:0];
                if (r_cnt == INV_LAST) begin
                    n_cnt   = '0;
                    n_rem   = {{(WORD_W-1){1'b0}}, (r_n != 32'd1)};
                    n_state = S_DBL;
                end else begin
                    n_cnt   = r_cnt + 6'd1;
                    n_state = S_NA;
                end
            end
            S_DBL: begin
                // 64 modular doublings of one give R^2 mod n.
                if (rem2 >= {1'b0, r_n}) begin
                    n_rem = t_word'(rem2 - {1'b0, r_n});
                end else begin
                    n_rem = rem2[WORD_W-1:0];
                end
                if (r_cnt == DBL_LAST) begin
                    n_cnt   = '0;
                    n_op    = OP_X0;
                    n_state = S_PROD;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_PROD: begin
                mul_en = 1'b1;
                if (r_op == OP_X0) begin
                    mul_a = r_base;
                    mul_b = r_rem;
                end else if (r_op == OP_MULT) begin
                    mul_a = r_acc;
                    mul_b = r_x;
                end else begin
                    mul_a = r_x;
                    mul_b = r_x;
                end
                n_state = S_RA;
            end
            S_RA: begin
                n_t     = t_src;
                mul_en  = 1'b1;
                mul_a   = t_src[WORD_W-1:0];
                mul_b   = r_ninv;
                n_state = S_RB;
            end
            S_RB: begin
                mul_en  = 1'b1;
                mul_a   = mul_p[WORD_W-1:0];
                mul_b   = r_n;
                n_state = S_RC;
            end
            S_RC: begin
                case (r_op)
                    OP_X0: begin
                        n_x     = red;
                        n_op    = OP_ACC0;
                        n_state = S_RA;
                    end
                    OP_ACC0: begin
                        n_acc   = red;
                        n_op    = r_e[0] ? OP_MULT : OP_SQR;
                        n_state = S_PROD;
                    end
                    OP_MULT: begin
                        n_acc   = red;
                        n_op    = OP_SQR;
                        n_state = S_PROD;
                    end
                    OP_SQR: begin
                        n_x = red;
                        if (r_cnt[4:0] == BIT_LAST) begin
                            n_op    = OP_FINAL;
                            n_state = S_RA;
                        end else begin
                            n_cnt   = r_cnt + 6'd1;
                            n_op    = r_e[nxt_bit] ? OP_MULT : OP_SQR;
                            n_state = S_PROD;
                        end
                    end
                    OP_FINAL: begin
                        n_res   = red;
                        n_err   = 1'b0;
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DONE: begin
                if (i_slot_free) begin
                    o_res.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_X0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_e    <= n_e;
        r_base <= n_base;
        r_ninv <= n_ninv;
        r_rem  <= n_rem;
        r_x    <= n_x;
        r_acc  <= n_acc;
        r_t    <= n_t;
        r_res  <= n_res;
        r_err  <= n_err;
    end

    `MMEU_ASSERT(a_busy_after_start, i_start |=> !o_ready, "sequencer still ready after start")
    `MMEU_ASSERT(a_done_needs_slot, o_res.done |-> i_slot_free, "result finished into full slot")
    `MMEU_ASSERT(a_rem_below_n, (r_state == S_DBL) |-> (r_rem < r_n), "R^2 remainder not below n")
    `MMEU_ASSERT(a_ninv_valid, (r_state == S_DBL) |-> (t_word'(r_n * r_ninv) == 32'd1), "bad n inverse")

endmodule

// ----- dv/mmeu_tb_pkg.sv -----
package mmeu_tb_pkg;
    import mmeu_pkg::*;

    // One expected output item.
    typedef struct packed {
        logic  err;
        t_word result;
    } t_expected;
endpackage

// ----- dv/tb_montgomery_modular_exponentiation_unit.sv -----
module tb_montgomery_modular_exponentiation_unit;
    import mmeu_pkg::*;
    import mmeu_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_word    i_cfg_data;

    mmeu_in_if  in_ch ();
    mmeu_out_if out_ch ();

    montgomery_modular_exponentiation_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow copies of the two registers, updated as they are written.
    t_word     cur_modulus;
    t_word     cur_exponent;
    t_expected pending_results[$];

    int mismatches;
    int results_seen;
    int items_sent;
    int idle_cycles;
    bit timed_out;

    // Plain square-and-multiply over 64-bit products; independent of the
    // Montgomery scheme the block uses, so it checks the math, not the method.
    function automatic t_expected predict_power(t_word base);
        t_expected e;
        logic [63:0] n;
        logic [63:0] b;
        logic [63:0] acc;
        e.err = 1'b0;
        e.result = '0;
        if (cur_modulus == 0 || cur_modulus[0] == 1'b0) begin
            e.err = 1'b1;
            return e;
        end
        n = {32'd0, cur_modulus};
        b = {32'd0, base} % n;
        acc = 64'd1 % n;
        for (int i = 0; i < WORD_W; i++) begin
            if (cur_exponent[i])
                acc = (acc * b) % n;
            b = (b * b) % n;
        end
        e.result = acc[31:0];
        return e;
    endfunction

    // Watchdog: counts cycles without any accepted item on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, compares every accepted result with the oldest
    // expectation. ready only drops when a stall is drawn.
    initial begin
        int stall;
        t_expected e;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk iff out_ch.valid);
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item %h err %b",
                             out_ch.result, out_ch.modulus_error);
            end else begin
                e = pending_results.pop_front();
                if (out_ch.result !== e.result || out_ch.modulus_error !== e.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h err %b, got %h err %b",
                                 e.result, e.err, out_ch.result, out_ch.modulus_error);
                end
            end
        end
    end

    // Sends one base item after a random gap and records its expectation.
    // valid stays high straight into the next item when no gap is drawn.
    task automatic send_base(t_word base);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.base  <= base;
        @(posedge i_clk iff in_ch.ready);
        pending_results.push_back(predict_power(base));
        items_sent++;
    endtask

    // Waits for every outstanding result, then lets the sequencer settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Drives one register write; the caller drops the write enable afterwards.
    task automatic write_reg(t_cfg_idx idx, t_word data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_MODULUS)
            cur_modulus = data;
        else
            cur_exponent = data;
    endtask

    task automatic set_key(t_word n, t_word e);
        wait_idle();
        write_reg(CFG_MODULUS, n);
        write_reg(CFG_EXPONENT, e);
        i_cfg_we <= 1'b0;
    endtask

    // With the reset values the modulus is one and every result is zero.
    task automatic test_reset_values();
        send_base(32'd0);
        send_base(32'hFFFF_FFFF);
        send_base(32'h1234_5678);
    endtask

    // Zero and even moduli must flag an error and give zero.
    task automatic test_bad_modulus();
        set_key(32'd0, 32'hFFFF_FFFF);
        send_base(32'd5);
        set_key(32'hFFFF_FFFE, 32'd3);
        send_base(32'hFFFF_FFFF);
        set_key(32'd2, 32'd1);
        send_base(32'd0);
    endtask

    // Extremes of base, modulus and exponent on valid moduli, including an
    // exponent of zero and bases that are not below the modulus.
    task automatic test_directed_extremes();
        set_key(32'hFFFF_FFFF, 32'd0);
        send_base(32'd0);
        send_base(32'hFFFF_FFFF);
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_base(32'd0);
        send_base(32'd1);
        send_base(32'hFFFF_FFFE);
        send_base(32'hFFFF_FFFF);
        set_key(32'd3, 32'h8000_0001);
        send_base(32'hFFFF_FFFF);
        send_base(32'd2);
        set_key(32'd1, 32'hFFFF_FFFF);
        send_base(32'hDEAD_BEEF);
        set_key(32'h8000_0001, 32'd65537);
        send_base(32'h8000_0000);
        send_base(32'h7FFF_FFFF);
        set_key(32'hC000_0001, 32'd1);
        send_base(32'hFFFF_FFFF);
    endtask

    // Random keys in phases, mostly odd moduli with a few bad ones. Each
    // phase runs a burst of random bases against the current key.
    task automatic test_random_keys();
        t_word n;
        t_word e;
        t_word b;
        int    burst;
        for (int phase = 0; phase < 65; phase++) begin
            case ($urandom_range(0, 9))
                0:       n = $urandom() & 32'hFFFF_FFFE;
                1:       n = $urandom_range(1, 255) | 32'd1;
                2:       n = 32'hFFFF_FFFF - 2 * $urandom_range(0, 15);
                default: n = $urandom() | 32'd1;
            endcase
            case ($urandom_range(0, 5))
                0:       e = $urandom_range(0, 3);
                1:       e = 32'hFFFF_FFFF ^ (32'd1 << $urandom_range(0, 31));
                default: e = $urandom();
            endcase
            set_key(n, e);
            burst = $urandom_range(12, 28);
            for (int k = 0; k < burst; k++) begin
                case ($urandom_range(0, 7))
                    0:       b = n;
                    1:       b = n - 1;
                    2:       b = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: b = $urandom();
                endcase
                send_base(b);
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_MODULUS;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.base   = '0;
        cur_modulus  = 32'd1;
        cur_exponent = 32'd0;
        mismatches   = 0;
        results_seen = 0;
        items_sent   = 0;
        idle_cycles  = 0;
        timed_out    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_bad_modulus();
        test_directed_extremes();
        test_random_keys();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d base items and checked %0d results over random keys,",
                 items_sent, results_seen);
        $display("including zero/even moduli, modulus one and exponent extremes.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     mismatches, pending_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
